### src/hash_bucketed_neighbor_pruner_core_defines.svh
`ifndef HASH_BUCKETED_NEIGHBOR_PRUNER_CORE_DEFINES_SVH
`define HASH_BUCKETED_NEIGHBOR_PRUNER_CORE_DEFINES_SVH

// Concurrent assertion clocked on clk_i and disabled while rst_ni is low.
`define HBNP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hbnp checker: assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define HBNP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("hbnp checker: assertion failed");

`endif

### src/hbnp_pkg.sv
package hbnp_pkg;

  localparam int unsigned HashW  = 16;
  localparam int unsigned NodeW  = 10;
  localparam int unsigned DistW  = 32;
  localparam int unsigned ProjW  = 16;
  localparam int unsigned CountW = 7;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_OFFER = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_IMPROVED = 3'd2;
  localparam logic [2:0] ST_EVICTED  = 3'd3;
  localparam logic [2:0] ST_DROPPED  = 3'd4;
  localparam logic [2:0] ST_SLOT     = 3'd5;
  localparam logic [2:0] ST_EMPTY    = 3'd6;

  localparam logic CFG_PLANE_COUNT = 1'b0;
  localparam logic CFG_SLOT_LIMIT  = 1'b1;

  typedef struct packed {
    logic [HashW-1:0] hash;
    logic [NodeW-1:0] id;
    logic [DistW-1:0] distance;
  } slot_t;

endpackage

### src/hbnp_ram.sv
module hbnp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/hash_bucketed_neighbor_pruner_core.sv
// Per-node neighbor reservoir keyed by a sign-bit hash of loaded projections. After reset the
// block clears the fill counts, one node per cycle (all NODES nodes, 1024 by default), and
// takes no transaction until that pass is done. A projection load is written when it is
// taken and then reported. An offered edge builds its hash with two projection reads per plane
// on the single read port of the projection memory and then drains the last read, scans the
// node's n slots, decides, shifts at most n slots (each read and then written) and places the
// new slot on an insert or eviction, and then reports. A read-out fetches the fill count and
// then reads and reports each slot in turn, each waiting on the read of the slot memory;
// output stall holds the report of any transaction and of each read-out slot.
// One transaction is in work at a time; a finished result waits in the output register while
// the next transaction is taken.
module hash_bucketed_neighbor_pruner_core #(
  parameter int unsigned NODES      = 1024,
  parameter int unsigned MAX_PLANES = 16,
  parameter int unsigned CAPACITY   = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_mode_i,
  input  logic [9:0]         in_node_i,
  input  logic [9:0]         in_other_node_i,
  input  logic [3:0]         in_plane_i,
  input  logic signed [15:0] in_projection_i,
  input  logic [31:0]        in_distance_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_status_o,
  output logic [9:0]         out_neighbor_id_o,
  output logic [31:0]        out_neighbor_distance_o,
  output logic [15:0]        out_slot_hash_o,
  output logic               out_last_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_wdata_i
);

  localparam int unsigned PDepth = NODES * MAX_PLANES;
  localparam int unsigned SDepth = NODES * CAPACITY;
  localparam int unsigned PAW    = PDepth > 1 ? $clog2(PDepth) : 1;
  localparam int unsigned SAW    = SDepth > 1 ? $clog2(SDepth) : 1;
  localparam int unsigned NAW    = NODES > 1 ? $clog2(NODES) : 1;
  localparam int unsigned SlotW  = $bits(hbnp_pkg::slot_t);

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_HASH    = 4'd2;
  localparam logic [3:0] S_SCAN    = 4'd3;
  localparam logic [3:0] S_DECIDE  = 4'd4;
  localparam logic [3:0] S_SH_RD   = 4'd5;
  localparam logic [3:0] S_SH_WR   = 4'd6;
  localparam logic [3:0] S_INS     = 4'd7;
  localparam logic [3:0] S_RO_FILL = 4'd8;
  localparam logic [3:0] S_RO_RD   = 4'd9;
  localparam logic [3:0] S_RO_WAIT = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  logic [3:0]  state_q, state_d;
  logic [4:0]  plane_count_q;
  logic [6:0]  slot_limit_q;
  logic [9:0]  u_q, u_d, v_q, v_d;
  logic [31:0] d_q, d_d;
  logic [15:0] hash_q, hash_d;
  logic [5:0]  k_q, k_d;
  logic        rdv_q, rdv_d, rdodd_q, rdodd_d;
  logic signed [15:0] pu_q, pu_d;
  logic [6:0]  n_q, n_d, i_q, i_d, pos_q, pos_d, far_q, far_d;
  logic        pos_found_q, pos_found_d, match_q, match_d;
  logic [31:0] match_dist_q, match_dist_d, far_dist_q, far_dist_d;
  logic [6:0]  sh_i_q, sh_i_d, sh_end_q, sh_end_d, ins_q, ins_d;
  logic        sh_up_q, sh_up_d;
  logic [2:0]  status_q, status_d;
  logic [NAW-1:0] clr_q, clr_d;

  logic        out_valid_q, out_valid_d, out_last_q, out_last_d;
  logic [2:0]  out_status_q, out_status_d;
  logic [9:0]  out_id_q, out_id_d;
  logic [31:0] out_dist_q, out_dist_d;
  logic [15:0] out_hash_q, out_hash_d;

  logic             p_we, p_re;
  logic [PAW-1:0]   p_waddr, p_raddr;
  logic [15:0]      p_rdata;
  logic             s_we, s_re;
  logic [SAW-1:0]   s_waddr, s_raddr;
  hbnp_pkg::slot_t  s_wdata, s_rdata;
  logic [SlotW-1:0] s_rdata_raw;
  logic             f_we, f_re;
  logic [NAW-1:0]   f_waddr, f_raddr;
  logic [6:0]       f_wdata, f_rdata;

  logic       accept, out_free, u_in_range, v_in_range;
  logic [4:0] planes;
  logic [6:0] limit, fill_n;
  logic [9:0] hash_node;
  logic [4:0] hash_plane;
  logic [6:0] scan_j;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign u_in_range = 32'(in_node_i) < NODES;
  assign v_in_range = 32'(in_other_node_i) < NODES;
  assign planes     = (32'(plane_count_q) > MAX_PLANES) ? 5'(MAX_PLANES) : plane_count_q;
  assign limit      = (32'(slot_limit_q) > CAPACITY) ? 7'(CAPACITY) : slot_limit_q;
  assign fill_n     = (32'(f_rdata) > CAPACITY) ? 7'(CAPACITY) : f_rdata;
  assign hash_node  = k_q[0] ? v_q : u_q;
  assign hash_plane = k_q[5:1];
  assign scan_j     = i_q - 7'd1;
  assign s_rdata    = hbnp_pkg::slot_t'(s_rdata_raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= 5'd12;
      slot_limit_q  <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hbnp_pkg::CFG_PLANE_COUNT: plane_count_q <= cfg_wdata_i[4:0];
        hbnp_pkg::CFG_SLOT_LIMIT:  slot_limit_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q; u_d = u_q; v_d = v_q; d_d = d_q; hash_d = hash_q;
    k_d = k_q; rdv_d = rdv_q; rdodd_d = rdodd_q; pu_d = pu_q;
    n_d = n_q; i_d = i_q; pos_d = pos_q; far_d = far_q;
    pos_found_d = pos_found_q; match_d = match_q;
    match_dist_d = match_dist_q; far_dist_d = far_dist_q;
    sh_i_d = sh_i_q; sh_end_d = sh_end_q; ins_d = ins_q; sh_up_d = sh_up_q;
    status_d = status_q; clr_d = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_status_d = out_status_q; out_id_d = out_id_q; out_dist_d = out_dist_q;
    out_hash_d = out_hash_q; out_last_d = out_last_q;

    p_we = 1'b0; p_waddr = PAW'(32'(in_node_i) * MAX_PLANES + 32'(in_plane_i));
    p_re = 1'b0; p_raddr = PAW'(32'(hash_node) * MAX_PLANES + 32'(hash_plane));
    s_we = 1'b0; s_waddr = '0; s_wdata = '{hash: hash_q, id: v_q, distance: d_q};
    s_re = 1'b0; s_raddr = '0;
    f_we = 1'b0; f_waddr = NAW'(u_q); f_wdata = n_q + 7'd1;
    f_re = 1'b0; f_raddr = NAW'(in_node_i);

    unique case (state_q)
      S_CLEAR: begin
        f_we = 1'b1; f_waddr = clr_q; f_wdata = '0;
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == NODES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          u_d = in_node_i; v_d = in_other_node_i; d_d = in_distance_i;
          hash_d = '0; k_d = '0; rdv_d = 1'b0;
          unique case (in_mode_i)
            hbnp_pkg::MODE_LOAD: begin
              p_we = u_in_range && (32'(in_plane_i) < MAX_PLANES);
              status_d = hbnp_pkg::ST_LOADED;
              state_d = S_EMIT;
            end
            hbnp_pkg::MODE_OFFER: begin
              f_re = u_in_range;
              status_d = hbnp_pkg::ST_DROPPED;
              state_d = (u_in_range && v_in_range) ? S_HASH : S_EMIT;
            end
            hbnp_pkg::MODE_READ: begin
              f_re = u_in_range;
              status_d = hbnp_pkg::ST_EMPTY;
              state_d = u_in_range ? S_RO_FILL : S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_HASH: begin
        if (rdv_q) begin
          if (rdodd_q) begin
            hash_d = {hash_q[14:0], pu_q >= $signed(p_rdata)};
          end else begin
            pu_d = $signed(p_rdata);
          end
        end
        if (k_q < {planes, 1'b0}) begin
          p_re = 1'b1; rdv_d = 1'b1; rdodd_d = k_q[0]; k_d = k_q + 6'd1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            n_d = fill_n; i_d = '0; pos_d = fill_n; pos_found_d = 1'b0;
            match_d = 1'b0; far_d = '0; far_dist_d = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rdv_q) begin
          if (!pos_found_q && s_rdata.hash >= hash_q) begin
            pos_d = scan_j; pos_found_d = 1'b1;
            match_d = (s_rdata.hash == hash_q);
            match_dist_d = s_rdata.distance;
          end
          if (scan_j == 7'd0 || s_rdata.distance > far_dist_q) begin
            far_d = scan_j; far_dist_d = s_rdata.distance;
          end
        end
        if (i_q < n_q) begin
          s_re = 1'b1; s_raddr = SAW'(32'(u_q) * CAPACITY + 32'(i_q));
          rdv_d = 1'b1; i_d = i_q + 7'd1;
        end else begin
          rdv_d = 1'b0;
          if (!rdv_q) begin
            state_d = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        state_d = S_EMIT;
        if (match_q) begin
          if (d_q < match_dist_q) begin
            s_we = 1'b1; s_waddr = SAW'(32'(u_q) * CAPACITY + 32'(pos_q));
            status_d = hbnp_pkg::ST_IMPROVED;
          end
        end else if (n_q < limit) begin
          f_we = 1'b1;
          sh_up_d = 1'b1; sh_i_d = n_q; sh_end_d = pos_q; ins_d = pos_q;
          status_d = hbnp_pkg::ST_INSERTED;
          state_d = S_SH_RD;
        end else if (n_q != 7'd0 && d_q < far_dist_q) begin
          status_d = hbnp_pkg::ST_EVICTED;
          state_d = S_SH_RD;
          // Removing the farthest slot and inserting in order nets to one shift of the
          // slots that lie between the two positions.
          if (far_q < pos_q) begin
            sh_up_d = 1'b0; sh_i_d = far_q + 7'd1; sh_end_d = pos_q; ins_d = pos_q - 7'd1;
          end else begin
            sh_up_d = 1'b1; sh_i_d = far_q; sh_end_d = pos_q; ins_d = pos_q;
          end
        end
      end
      S_SH_RD: begin
        if (sh_up_q ? (sh_i_q > sh_end_q) : (sh_i_q < sh_end_q)) begin
          s_re = 1'b1;
          s_raddr = SAW'(32'(u_q) * CAPACITY + 32'(sh_up_q ? sh_i_q - 7'd1 : sh_i_q));
          state_d = S_SH_WR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SH_WR: begin
        s_we = 1'b1; s_wdata = s_rdata;
        s_waddr = SAW'(32'(u_q) * CAPACITY + 32'(sh_up_q ? sh_i_q : sh_i_q - 7'd1));
        sh_i_d = sh_up_q ? sh_i_q - 7'd1 : sh_i_q + 7'd1;
        state_d = S_SH_RD;
      end
      S_INS: begin
        s_we = 1'b1; s_waddr = SAW'(32'(u_q) * CAPACITY + 32'(ins_q));
        state_d = S_EMIT;
      end
      S_RO_FILL: begin
        n_d = fill_n; i_d = '0;
        state_d = (fill_n == 7'd0) ? S_EMIT : S_RO_RD;
      end
      S_RO_RD: begin
        s_re = 1'b1; s_raddr = SAW'(32'(u_q) * CAPACITY + 32'(i_q));
        state_d = S_RO_WAIT;
      end
      S_RO_WAIT: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_status_d = hbnp_pkg::ST_SLOT;
          out_id_d = s_rdata.id; out_dist_d = s_rdata.distance; out_hash_d = s_rdata.hash;
          out_last_d = (i_q + 7'd1 == n_q);
          i_d = i_q + 7'd1;
          state_d = (i_q + 7'd1 == n_q) ? S_IDLE : S_RO_RD;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1; out_status_d = status_q;
          out_id_d = '0; out_dist_d = '0; out_hash_d = hash_q; out_last_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rdv_q       <= rdv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d; v_q <= v_d; d_q <= d_d; hash_q <= hash_d; k_q <= k_d;
    rdodd_q <= rdodd_d; pu_q <= pu_d; n_q <= n_d; i_q <= i_d; pos_q <= pos_d;
    far_q <= far_d; pos_found_q <= pos_found_d; match_q <= match_d;
    match_dist_q <= match_dist_d; far_dist_q <= far_dist_d;
    sh_i_q <= sh_i_d; sh_end_q <= sh_end_d; ins_q <= ins_d; sh_up_q <= sh_up_d;
    status_q <= status_d;
    out_status_q <= out_status_d; out_id_q <= out_id_d; out_dist_q <= out_dist_d;
    out_hash_q <= out_hash_d; out_last_q <= out_last_d;
  end

  hbnp_ram #(.Width(16), .Depth(PDepth)) u_proj_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(in_projection_i),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  hbnp_ram #(.Width(SlotW), .Depth(SDepth)) u_slot_ram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .re_i(s_re), .raddr_i(s_raddr), .rdata_o(s_rdata_raw)
  );

  hbnp_ram #(.Width(7), .Depth(NODES)) u_fill_ram (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .re_i(f_re), .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  assign out_valid_o             = out_valid_q;
  assign out_status_o            = out_status_q;
  assign out_neighbor_id_o       = out_id_q;
  assign out_neighbor_distance_o = out_dist_q;
  assign out_slot_hash_o         = out_hash_q;
  assign out_last_o              = out_last_q;

endmodule

### src/hbnp_checker.sv
`include "hash_bucketed_neighbor_pruner_core_defines.svh"

module hbnp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  in_mode_i,
  input logic [9:0]  in_node_i,
  input logic [9:0]  in_other_node_i,
  input logic [3:0]  in_plane_i,
  input logic [15:0] in_projection_i,
  input logic [31:0] in_distance_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  out_status_o,
  input logic [9:0]  out_neighbor_id_o,
  input logic [31:0] out_neighbor_distance_o,
  input logic [15:0] out_slot_hash_o,
  input logic        out_last_o,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [6:0]  cfg_wdata_i
);

  // A stalled result stays offered.
  `HBNP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)

  // Every result other than a read-out slot is the only one of its transaction.
  `HBNP_ASSERT(a_single_last, out_valid_o && out_status_o != hbnp_pkg::ST_SLOT |-> out_last_o)

  // Empty read-outs and loads carry no hash and no neighbor.
  `HBNP_ASSERT(a_empty_zero, out_valid_o && (out_status_o == hbnp_pkg::ST_EMPTY || out_status_o == hbnp_pkg::ST_LOADED) |-> out_slot_hash_o == 16'd0 && out_neighbor_id_o == 10'd0)

  // Only read-out slots report a stored distance.
  `HBNP_ASSERT(a_dist_zero, out_valid_o && out_status_o != hbnp_pkg::ST_SLOT |-> out_neighbor_distance_o == 32'd0)

endmodule

bind hash_bucketed_neighbor_pruner_core hbnp_checker u_hbnp_checker (.*);

### sim/tb_hash_bucketed_neighbor_pruner_core.sv
module tb_hash_bucketed_neighbor_pruner_core;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  status;
    logic [9:0]  id;
    logic [31:0] distance;
    logic [15:0] hash;
    logic        last;
  } result_t;

  // Predictor of the reservoir block plus the queue of results it expects.
  class reservoir_scoreboard;
    logic [15:0] proj_mem [0:16383];
    logic [15:0] slot_hash [0:1023][0:63];
    logic [9:0]  slot_id [0:1023][0:63];
    logic [31:0] slot_dist [0:1023][0:63];
    int          fill [0:1023];
    int          planes;
    int          limit;
    result_t     pending [$];
    int          errors;

    function new();
      planes = 12;
      limit = 64;
      errors = 0;
      foreach (fill[i]) fill[i] = 0;
      foreach (proj_mem[i]) proj_mem[i] = '0;
    endfunction

    function void set_reg(logic idx, logic [6:0] val);
      if (idx == hbnp_pkg::CFG_PLANE_COUNT) planes = int'(val[4:0]);
      else limit = int'(val);
    endfunction

    function void push(logic [2:0] st, logic [9:0] id, logic [31:0] d, logic [15:0] h,
                       logic l);
      result_t r;
      r.status = st; r.id = id; r.distance = d; r.hash = h; r.last = l;
      pending = {pending, r};
    endfunction

    function int find_pos(int u, int n, logic [15:0] h);
      int p;
      p = 0;
      while (p < n && slot_hash[u][p] < h) p++;
      return p;
    endfunction

    function void insert_slot(int u, int n, int pos, logic [15:0] h, logic [9:0] v,
                              logic [31:0] d);
      for (int i = n; i > pos; i--) begin
        slot_hash[u][i] = slot_hash[u][i-1];
        slot_id[u][i] = slot_id[u][i-1];
        slot_dist[u][i] = slot_dist[u][i-1];
      end
      slot_hash[u][pos] = h;
      slot_id[u][pos] = v;
      slot_dist[u][pos] = d;
    endfunction

    function logic [2:0] offer_edge(int u, int v, logic [31:0] d, output logic [15:0] h);
      int np, lim, n, pos, far;
      np = planes > 16 ? 16 : planes;
      lim = limit > 64 ? 64 : limit;
      h = '0;
      for (int p = 0; p < np; p++)
        h = {h[14:0], $signed(proj_mem[u*16+p]) >= $signed(proj_mem[v*16+p])};
      n = fill[u];
      pos = find_pos(u, n, h);
      if (pos < n && slot_hash[u][pos] == h) begin
        if (d < slot_dist[u][pos]) begin
          slot_id[u][pos] = 10'(v);
          slot_dist[u][pos] = d;
          return hbnp_pkg::ST_IMPROVED;
        end
        return hbnp_pkg::ST_DROPPED;
      end
      if (n < lim) begin
        insert_slot(u, n, pos, h, 10'(v), d);
        fill[u] = n + 1;
        return hbnp_pkg::ST_INSERTED;
      end
      if (n == 0) return hbnp_pkg::ST_DROPPED;
      far = 0;
      for (int i = 1; i < n; i++)
        if (slot_dist[u][i] > slot_dist[u][far]) far = i;
      if (!(d < slot_dist[u][far])) return hbnp_pkg::ST_DROPPED;
      for (int i = far; i + 1 < n; i++) begin
        slot_hash[u][i] = slot_hash[u][i+1];
        slot_id[u][i] = slot_id[u][i+1];
        slot_dist[u][i] = slot_dist[u][i+1];
      end
      pos = find_pos(u, n - 1, h);
      insert_slot(u, n - 1, pos, h, 10'(v), d);
      return hbnp_pkg::ST_EVICTED;
    endfunction

    function void note_input(logic [1:0] mode, logic [9:0] u, logic [9:0] v,
                             logic [3:0] plane, logic [15:0] proj, logic [31:0] d);
      logic [15:0] h;
      logic [2:0]  st;
      if (mode == hbnp_pkg::MODE_LOAD) begin
        proj_mem[int'(u)*16 + int'(plane)] = proj;
        push(hbnp_pkg::ST_LOADED, 10'd0, 32'd0, 16'd0, 1'b1);
      end else if (mode == hbnp_pkg::MODE_OFFER) begin
        st = offer_edge(int'(u), int'(v), d, h);
        push(st, 10'd0, 32'd0, h, 1'b1);
      end else if (mode == hbnp_pkg::MODE_READ) begin
        if (fill[u] == 0) push(hbnp_pkg::ST_EMPTY, 10'd0, 32'd0, 16'd0, 1'b1);
        else
          for (int i = 0; i < fill[u]; i++)
            push(hbnp_pkg::ST_SLOT, slot_id[u][i], slot_dist[u][i], slot_hash[u][i],
                 i + 1 == fill[u]);
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report_mismatch("status");
      if (got.id !== want.id) report_mismatch("neighbor_id");
      if (got.distance !== want.distance) report_mismatch("neighbor_distance");
      if (got.hash !== want.hash) report_mismatch("slot_hash");
      if (got.last !== want.last) report_mismatch("last");
    endtask
  endclass

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_stall_o;
  logic [1:0]  in_mode_i;
  logic [9:0]  in_node_i, in_other_node_i;
  logic [3:0]  in_plane_i;
  logic signed [15:0] in_projection_i;
  logic [31:0] in_distance_i;
  logic        out_valid_o, out_stall_i;
  logic [2:0]  out_status_o;
  logic [9:0]  out_neighbor_id_o;
  logic [31:0] out_neighbor_distance_o;
  logic [15:0] out_slot_hash_o;
  logic        out_last_o;
  logic        cfg_we_i, cfg_index_i;
  logic [6:0]  cfg_wdata_i;

  hash_bucketed_neighbor_pruner_core u_top (.*);

  reservoir_scoreboard sb;
  bit   hold_output;
  int   idle_cycles;
  bit   loaded [0:1023];
  // Nodes with every plane loaded; offers only use these.
  int   ready_nodes [$];

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  // Valid stays high from one transaction to the next when no idle gap is drawn.
  task automatic send_item(logic [1:0] mode, logic [9:0] u, logic [9:0] v,
                           logic [3:0] plane, logic [15:0] proj, logic [31:0] d);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_mode_i <= mode;
    in_node_i <= u;
    in_other_node_i <= v;
    in_plane_i <= plane;
    in_projection_i <= proj;
    in_distance_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(mode, u, v, plane, proj, d);
    @(negedge clk_i);
  endtask

  task automatic load_node(int u);
    for (int p = 0; p < 16; p++)
      send_item(hbnp_pkg::MODE_LOAD, 10'(u), 10'd0, 4'(p),
                16'($urandom_range(0, 7) - 3), 32'd0);
    if (!loaded[u]) ready_nodes = {ready_nodes, u};
    loaded[u] = 1;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_offer(bit small_dist);
    int u, v;
    u = ready_nodes[$urandom_range(0, 3)];
    v = ready_nodes[$urandom_range(0, ready_nodes.size() - 1)];
    send_item(hbnp_pkg::MODE_OFFER, 10'(u), 10'(v), 4'd0, 16'd0,
              small_dist ? 32'($urandom_range(0, 4000)) : $urandom());
  endtask

  // Receiver: a drawn wait per result, plus one long hold-off while the sender keeps going.
  initial begin
    result_t r;
    int stall_left;
    out_stall_i = 0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        r.status = out_status_o; r.id = out_neighbor_id_o;
        r.distance = out_neighbor_distance_o; r.hash = out_slot_hash_o;
        r.last = out_last_o;
        sb.check_result(r);
        stall_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      end
      @(negedge clk_i);
      if (hold_output) out_stall_i <= 1'b1;
      else if (stall_left > 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else out_stall_i <= 1'b0;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("hash_bucketed_neighbor_pruner_core test failed");
        $finish;
      end
    end
  end

  initial begin
    sb = new();
    idle_cycles = 0;
    hold_output = 0;
    foreach (loaded[i]) loaded[i] = 0;
    rst_ni = 0;
    in_valid_i = 0; in_mode_i = '0; in_node_i = '0; in_other_node_i = '0;
    in_plane_i = '0; in_projection_i = '0; in_distance_i = '0;
    cfg_we_i = 0; cfg_index_i = 0; cfg_wdata_i = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1;

    // Directed: extreme projections and node ids, empty read, limit-zero drop.
    send_item(hbnp_pkg::MODE_LOAD, 10'd1023, 10'd0, 4'd15, 16'h8000, 32'd0);
    send_item(hbnp_pkg::MODE_LOAD, 10'd1023, 10'd0, 4'd15, 16'h7fff, 32'd0);
    send_item(hbnp_pkg::MODE_READ, 10'd1023, 10'd0, 4'd0, 16'd0, 32'd0);
    for (int u = 0; u < 4; u++) load_node(u);
    load_node(1023);
    settle();
    write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd0);
    send_item(hbnp_pkg::MODE_OFFER, 10'd0, 10'd1, 4'd0, 16'd0, 32'd5);
    settle();
    write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd127);
    write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd0);
    send_item(hbnp_pkg::MODE_OFFER, 10'd0, 10'd1, 4'd0, 16'd0, 32'hffffffff);
    send_item(hbnp_pkg::MODE_OFFER, 10'd0, 10'd2, 4'd0, 16'd0, 32'hffffffff);
    send_item(hbnp_pkg::MODE_OFFER, 10'd0, 10'd3, 4'd0, 16'd0, 32'd0);
    send_item(hbnp_pkg::MODE_OFFER, 10'd1023, 10'd1023, 4'd0, 16'd0, 32'd9);
    send_item(hbnp_pkg::MODE_READ, 10'd0, 10'd0, 4'd0, 16'd0, 32'd0);
    send_item(hbnp_pkg::MODE_NONE, 10'h3ff, 10'h3ff, 4'hf, 16'hffff, 32'hffffffff);
    settle();
    write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd31);

    // Random phases over several register settings.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd16);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd64);
        end
        1: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd1);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd1);
        end
        2: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd4);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd3);
        end
        3: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd6);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd8);
        end
        4: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd3);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd2);
        end
        default: begin
          write_reg(hbnp_pkg::CFG_PLANE_COUNT, 7'd12);
          write_reg(hbnp_pkg::CFG_SLOT_LIMIT, 7'd0);
        end
      endcase
      if (ph == 2) fork
        begin
          hold_output = 1;
          repeat (600) @(negedge clk_i);
          hold_output = 0;
        end
      join_none
      for (int k = 0; k < 56; k++) begin
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) random_offer($urandom_range(0, 1));
        else if (pick < 16)
          send_item(hbnp_pkg::MODE_READ, 10'(ready_nodes[$urandom_range(0, 3)]), 10'd0,
                    4'd0, 16'd0, 32'd0);
        else if (pick < 18)
          send_item(hbnp_pkg::MODE_LOAD, 10'($urandom_range(4, 1022)), 10'($urandom()),
                    4'($urandom()), 16'($urandom()), $urandom());
        else if (pick == 18)
          send_item(hbnp_pkg::MODE_READ, 10'($urandom_range(4, 1022)), 10'($urandom()),
                    4'd0, 16'd0, 32'd0);
        else
          send_item(hbnp_pkg::MODE_NONE, 10'($urandom()), 10'($urandom()), 4'($urandom()),
                    16'($urandom()), $urandom());
      end
      settle();
    end
    for (int u = 0; u < 4; u++)
      send_item(hbnp_pkg::MODE_READ, 10'(u), 10'd0, 4'd0, 16'd0, 32'd0);
    settle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("hash_bucketed_neighbor_pruner_core test passed");
    else
      $display("hash_bucketed_neighbor_pruner_core test failed");
    $finish;
  end
endmodule

### filelist.f
+incdir+src
src/hbnp_pkg.sv
src/hbnp_ram.sv
src/hash_bucketed_neighbor_pruner_core.sv
src/hbnp_checker.sv
sim/tb_hash_bucketed_neighbor_pruner_core.sv
